/* rtl/png_row_unfilter_unit_defines.svh */
// ---------------------------------------------------------------------------
// PNG row unfilter - assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef PNG_ROW_UNFILTER_UNIT_DEFINES_SVH
`define PNG_ROW_UNFILTER_UNIT_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent
`define PRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent
`define PRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pru_pkg.sv */
// ---------------------------------------------------------------------------
// PNG row unfilter - package
// Geometry constants, register indexes, filter codes and shared structs.
// ---------------------------------------------------------------------------
`default_nettype none

package pru_pkg;

  // Geometry limits
  localparam int MAX_WIDTH = 4096;
  localparam int ROW_BYTES = 16384;
  localparam int COL_W     = $clog2(ROW_BYTES);
  localparam int ROWB_W    = COL_W + 1;

  // Register and port widths
  localparam int IMG_W_W   = 13;
  localparam int IMG_H_W   = 16;
  localparam int MODE_W    = 2;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 4;
  localparam int REG_IDX_W = 2;
  localparam int BYTE_W    = 8;

  // Register indexes (byte address / 4)
  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_COLOR_MODE   = 2'd2
  } reg_idx_t;

  // Colour modes
  localparam logic [MODE_W-1:0] MODE_PALETTE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RGB     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RGBA    = 2'd2;

  // Byte lane of the window that sits one pixel back
  localparam logic [1:0] LANE_STRIDE1 = 2'd0;
  localparam logic [1:0] LANE_STRIDE3 = 2'd2;
  localparam logic [1:0] LANE_STRIDE4 = 2'd3;

  // Row filter types
  localparam logic [BYTE_W-1:0] FILT_NONE  = 8'd0;
  localparam logic [BYTE_W-1:0] FILT_SUB   = 8'd1;
  localparam logic [BYTE_W-1:0] FILT_UP    = 8'd2;
  localparam logic [BYTE_W-1:0] FILT_AVG   = 8'd3;
  localparam logic [BYTE_W-1:0] FILT_PAETH = 8'd4;

  localparam logic [BYTE_W-1:0] ALPHA_FILL = 8'hFF;

  typedef struct packed {
    logic [IMG_W_W-1:0] image_width;
    logic [IMG_H_W-1:0] image_height;
    logic [MODE_W-1:0]  color_mode;
  } cfg_t;

  // One reconstructed byte plus its alpha flag and row markers
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has_alpha;
    logic              row_done;
    logic              image_done;
  } res_t;

endpackage

`default_nettype wire

/* rtl/pru_stream_if.sv */
// ---------------------------------------------------------------------------
// PNG row unfilter - stream interfaces
// Valid/ready channels for filtered input bytes and reconstructed results.
// ---------------------------------------------------------------------------
`default_nettype none

interface pru_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface pru_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_in_run;
  logic       row_done;
  logic       image_done;

  modport source (output valid, output out_byte, output last_in_run,
                  output row_done, output image_done, input ready);
  modport sink   (input valid, input out_byte, input last_in_run,
                  input row_done, input image_done, output ready);
endinterface

`default_nettype wire

/* rtl/pru_ram.sv */
// ---------------------------------------------------------------------------
// PNG row unfilter - generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/pru_cfg_regs.sv */
// ---------------------------------------------------------------------------
// PNG row unfilter - configuration registers
// APB-style register file for image width, height and colour mode.
// ---------------------------------------------------------------------------
`default_nettype none

module pru_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pru_pkg::PADDR_W-1:0]   paddr,
  input  logic [pru_pkg::DATA_W-1:0]    pwdata,
  output logic [pru_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output pru_pkg::cfg_t                 cfg
);
  import pru_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[REG_IDX_W+1:2];

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_IMAGE_WIDTH:  cfg_nxt.image_width  = pwdata[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: cfg_nxt.image_height = pwdata[IMG_H_W-1:0];
        REG_COLOR_MODE:   cfg_nxt.color_mode   = pwdata[MODE_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= IMG_W_W'(1);
      cfg_r.image_height <= IMG_H_W'(1);
      cfg_r.color_mode   <= MODE_RGBA;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:  prdata = DATA_W'(cfg_r.image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(cfg_r.image_height);
      REG_COLOR_MODE:   prdata = DATA_W'(cfg_r.color_mode);
      default:          prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/pru_recon.sv */
// ---------------------------------------------------------------------------
// PNG row unfilter - byte reconstruction
// Applies the row filter to one sample from its left, upper, upper-left bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module pru_recon (
  input  logic [pru_pkg::BYTE_W-1:0] filt,
  input  logic [pru_pkg::BYTE_W-1:0] x,
  input  logic [pru_pkg::BYTE_W-1:0] a,
  input  logic [pru_pkg::BYTE_W-1:0] b,
  input  logic [pru_pkg::BYTE_W-1:0] c,
  output logic [pru_pkg::BYTE_W-1:0] r
);
  import pru_pkg::*;

  logic [BYTE_W:0]        avg_sum;
  logic signed [BYTE_W+1:0] d_a;
  logic signed [BYTE_W+1:0] d_b;
  logic signed [BYTE_W+1:0] d_c;
  logic [BYTE_W:0]        pa;
  logic [BYTE_W:0]        pb;
  logic [BYTE_W:0]        pc;
  logic [BYTE_W-1:0]      pred;

  assign avg_sum = {1'b0, a} + {1'b0, b};

  // Paeth distances: |b-c|, |a-c|, |a+b-2c|
  assign d_a = $signed({2'b00, b}) - $signed({2'b00, c});
  assign d_b = $signed({2'b00, a}) - $signed({2'b00, c});
  assign d_c = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
  assign pa  = d_a[BYTE_W+1] ? (BYTE_W+1)'(-d_a) : (BYTE_W+1)'(d_a);
  assign pb  = d_b[BYTE_W+1] ? (BYTE_W+1)'(-d_b) : (BYTE_W+1)'(d_b);
  assign pc  = d_c[BYTE_W+1] ? (BYTE_W+1)'(-d_c) : (BYTE_W+1)'(d_c);

  // Pick the nearest neighbour, a first, then b
  always_comb begin
    if (pa <= pb && pa <= pc) begin
      pred = a;
    end else if (pb <= pc) begin
      pred = b;
    end else begin
      pred = c;
    end
  end

  always_comb begin
    case (filt)
      FILT_NONE:  r = x;
      FILT_SUB:   r = x + a;
      FILT_UP:    r = x + b;
      FILT_AVG:   r = x + avg_sum[BYTE_W:1];
      FILT_PAETH: r = x + pred;
      default:    r = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/pru_out_stage.sv */
// ---------------------------------------------------------------------------
// PNG row unfilter - output register
// Holds one reconstructed byte and, in RGB mode, sends the alpha fill after it.
// ---------------------------------------------------------------------------
`default_nettype none

module pru_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  pru_pkg::res_t    res,
  output logic             free,
  pru_out_if.source        out_if
);
  import pru_pkg::*;

  logic ov_r;
  logic ov_nxt;
  logic ph_r;
  logic ph_nxt;
  res_t res_r;
  logic fin;

  // Final transfer of the held item: alpha phase, or no alpha to follow
  assign fin  = ph_r || !res_r.has_alpha;
  assign free = !ov_r || (out_if.ready && fin);

  always_comb begin
    ov_nxt = ov_r;
    ph_nxt = ph_r;
    if (load) begin
      ov_nxt = 1'b1;
      ph_nxt = 1'b0;
    end else if (ov_r && out_if.ready) begin
      if (fin) begin
        ov_nxt = 1'b0;
      end else begin
        ph_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      ph_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      ph_r <= ph_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_if.valid       = ov_r;
  assign out_if.out_byte    = ph_r ? ALPHA_FILL : res_r.data;
  assign out_if.last_in_run = fin;
  assign out_if.row_done    = fin && res_r.row_done;
  assign out_if.image_done  = fin && res_r.image_done;

endmodule

`default_nettype wire

/* rtl/png_row_unfilter_unit.sv */
// Each sample is registered at transfer in and moves to the output register once that is free.
// One input byte per cycle unless the output stalls; a filter type byte gives no result.
// RGB mode: the alpha fill is its own output transfer and stalls input once per pixel.
// The previous-row memory has a registered read issued at input transfer.
// Reset clears control state and the neighbour windows; the previous-row memory is not
// cleared and the first row of each image reads it as zero.
`default_nettype none

// ---------------------------------------------------------------------------
// PNG row unfilter - top level
// Reconstructs PNG scanline bytes (none, sub, up, average, Paeth filters).
// ---------------------------------------------------------------------------
module png_row_unfilter_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  pru_in_if.sink                      in_if,
  pru_out_if.source                   out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pru_pkg::PADDR_W-1:0] paddr,
  input  logic [pru_pkg::DATA_W-1:0]  pwdata,
  output logic [pru_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import pru_pkg::*;

`include "png_row_unfilter_unit_defines.svh"

  cfg_t               cfg;

  // Row tracking state
  logic               expect_filt_r;
  logic               expect_filt_nxt;
  logic [COL_W-1:0]   col_r;
  logic [COL_W-1:0]   col_nxt;
  logic [1:0]         mod3_r;
  logic [1:0]         mod3_nxt;
  logic [IMG_H_W-1:0] row_idx_r;
  logic [IMG_H_W-1:0] row_idx_nxt;
  logic               first_row_r;
  logic               first_row_nxt;
  logic [BYTE_W-1:0]  row_filt_r;
  logic [BYTE_W-1:0]  row_filt_nxt;

  // Input register
  logic               s1_v_r;
  logic               s1_v_nxt;
  logic [BYTE_W-1:0]  s1_x_r;
  logic [COL_W-1:0]   s1_col_r;
  logic               s1_first_r;
  logic [BYTE_W-1:0]  s1_filt_r;
  logic               s1_left_r;
  logic [1:0]         s1_lane_r;
  logic               s1_alpha_r;
  logic               s1_row_end_r;
  logic               s1_img_end_r;

  // Neighbour windows
  logic [4*BYTE_W-1:0] left_win_r;
  logic [4*BYTE_W-1:0] upleft_win_r;

  // Geometry
  logic [IMG_W_W-1:0] w_eff;
  logic [IMG_H_W-1:0] h_eff;
  logic [2:0]         stride;
  logic [1:0]         lane;
  logic [ROWB_W-1:0]  row_len_raw;
  logic [ROWB_W-1:0]  row_len;
  logic               row_end;
  logic               img_end;
  logic               alpha_here;

  // Handshake
  logic               acc;
  logic               smp_acc;
  logic               filt_acc;
  logic               s1_adv;
  logic               out_free;

  // Datapath
  logic [BYTE_W-1:0]  ram_rdata;
  logic [BYTE_W-1:0]  a_byte;
  logic [BYTE_W-1:0]  b_byte;
  logic [BYTE_W-1:0]  c_byte;
  logic [BYTE_W-1:0]  r_byte;
  res_t               res;

  pru_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Clamp the geometry
  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = IMG_W_W'(1);
    end else if (cfg.image_width > IMG_W_W'(MAX_WIDTH)) begin
      w_eff = IMG_W_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg.image_width;
    end
    h_eff = (cfg.image_height == '0) ? IMG_H_W'(1) : cfg.image_height;
  end

  always_comb begin
    case (cfg.color_mode)
      MODE_PALETTE: begin
        stride      = 3'd1;
        lane        = LANE_STRIDE1;
        row_len_raw = ROWB_W'(w_eff);
      end
      MODE_RGB: begin
        stride      = 3'd3;
        lane        = LANE_STRIDE3;
        row_len_raw = ROWB_W'({w_eff, 1'b0}) + ROWB_W'(w_eff);
      end
      default: begin
        stride      = 3'd4;
        lane        = LANE_STRIDE4;
        row_len_raw = ROWB_W'({w_eff, 2'b00});
      end
    endcase
    row_len = (row_len_raw > ROWB_W'(ROW_BYTES)) ? ROWB_W'(ROW_BYTES) : row_len_raw;
  end

  assign row_end    = (ROWB_W'(col_r) + ROWB_W'(1)) >= row_len;
  assign img_end    = row_end &&
                      (({1'b0, row_idx_r} + (IMG_H_W+1)'(1)) >= {1'b0, h_eff});
  assign alpha_here = (cfg.color_mode == MODE_RGB) && (mod3_r == 2'd2);

  // Handshake: take a byte whenever the input register empties or moves on
  assign s1_adv      = s1_v_r && out_free;
  assign in_if.ready = !s1_v_r || s1_adv;
  assign acc         = in_if.valid && in_if.ready;
  assign smp_acc     = acc && !expect_filt_r;
  assign filt_acc    = acc && expect_filt_r;

  // Advance row, column and image position
  always_comb begin
    expect_filt_nxt = expect_filt_r;
    col_nxt         = col_r;
    mod3_nxt        = mod3_r;
    row_idx_nxt     = row_idx_r;
    first_row_nxt   = first_row_r;
    row_filt_nxt    = row_filt_r;
    if (filt_acc) begin
      row_filt_nxt    = in_if.data_byte;
      expect_filt_nxt = 1'b0;
      col_nxt         = '0;
      mod3_nxt        = 2'd0;
    end else if (smp_acc) begin
      if (row_end) begin
        expect_filt_nxt = 1'b1;
        col_nxt         = '0;
        mod3_nxt        = 2'd0;
        if (img_end) begin
          row_idx_nxt   = '0;
          first_row_nxt = 1'b1;
        end else begin
          row_idx_nxt   = row_idx_r + IMG_H_W'(1);
          first_row_nxt = 1'b0;
        end
      end else begin
        col_nxt  = col_r + COL_W'(1);
        mod3_nxt = (mod3_r == 2'd2) ? 2'd0 : mod3_r + 2'd1;
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (smp_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_filt_r <= 1'b1;
      col_r         <= '0;
      mod3_r        <= 2'd0;
      row_idx_r     <= '0;
      first_row_r   <= 1'b1;
      row_filt_r    <= FILT_NONE;
      s1_v_r        <= 1'b0;
    end else begin
      expect_filt_r <= expect_filt_nxt;
      col_r         <= col_nxt;
      mod3_r        <= mod3_nxt;
      row_idx_r     <= row_idx_nxt;
      first_row_r   <= first_row_nxt;
      row_filt_r    <= row_filt_nxt;
      s1_v_r        <= s1_v_nxt;
    end
  end

  // Capture the sample and its position
  always_ff @(posedge clk) begin
    if (smp_acc) begin
      s1_x_r       <= in_if.data_byte;
      s1_col_r     <= col_r;
      s1_first_r   <= first_row_r;
      s1_filt_r    <= row_filt_r;
      s1_left_r    <= col_r >= COL_W'(stride);
      s1_lane_r    <= lane;
      s1_alpha_r   <= alpha_here;
      s1_row_end_r <= row_end;
      s1_img_end_r <= img_end;
    end
  end

  // Previous row store: read at transfer in, write when the byte moves on
  pru_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (ROW_BYTES)
  ) u_prior_row (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (r_byte),
    .re    (smp_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // Select the neighbours one pixel back
  always_comb begin
    case (s1_lane_r)
      LANE_STRIDE1: begin
        a_byte = left_win_r[BYTE_W-1:0];
        c_byte = upleft_win_r[BYTE_W-1:0];
      end
      LANE_STRIDE3: begin
        a_byte = left_win_r[3*BYTE_W-1:2*BYTE_W];
        c_byte = upleft_win_r[3*BYTE_W-1:2*BYTE_W];
      end
      default: begin
        a_byte = left_win_r[4*BYTE_W-1:3*BYTE_W];
        c_byte = upleft_win_r[4*BYTE_W-1:3*BYTE_W];
      end
    endcase
    if (!s1_left_r) begin
      a_byte = '0;
      c_byte = '0;
    end
  end

  assign b_byte = s1_first_r ? '0 : ram_rdata;

  pru_recon u_recon (
    .filt (s1_filt_r),
    .x    (s1_x_r),
    .a    (a_byte),
    .b    (b_byte),
    .c    (c_byte),
    .r    (r_byte)
  );

  // Shift the windows as each byte moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_win_r   <= '0;
      upleft_win_r <= '0;
    end else if (s1_adv) begin
      left_win_r   <= {left_win_r[3*BYTE_W-1:0], r_byte};
      upleft_win_r <= {upleft_win_r[3*BYTE_W-1:0], b_byte};
    end
  end

  always_comb begin
    res.data       = r_byte;
    res.has_alpha  = s1_alpha_r;
    res.row_done   = s1_row_end_r;
    res.image_done = s1_img_end_r;
  end

  pru_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (s1_adv),
    .res    (res),
    .free   (out_free),
    .out_if (out_if)
  );

  // Checks
  `PRU_ASSERT_NEXT(a_s1_hold, s1_v_r && !s1_adv, s1_v_r && $stable(s1_col_r),
                   "stalled sample lost its column")
  `PRU_ASSERT_NEXT(a_row_wrap, smp_acc && row_end, expect_filt_r && (col_r == '0),
                   "row end did not return to filter byte")
  `PRU_ASSERT_NOW(a_img_row, out_if.valid && out_if.image_done,
                  out_if.row_done && out_if.last_in_run,
                  "image end without row end")

endmodule

`default_nettype wire
